// File: design/vmat_pkg.sv
// Shared types, constants and codes for the validated multi-turn angle tracker.
`default_nettype none

package vmat_pkg;

   // Geometry of the tracker
   localparam int NUM_ENCODERS = 6;
   localparam int ANGLE_BITS   = 21;
   localparam int ENC_ADDR_W   = $clog2(NUM_ENCODERS);

   // Field widths of the stream words
   localparam int IDX_W      = 3;
   localparam int IDX_SPAN   = 1 << IDX_W;
   localparam int RAW_W      = 21;
   localparam int STATUS_W   = 3;
   localparam int ELAPSED_W  = 20;
   localparam int SPIKE_W    = 24;
   localparam int SPIKE_FRAC = 16;
   localparam int LIMIT_W    = 3;
   localparam int ENABLE_W   = 6;
   localparam int ATTEMPT_W  = 3;
   localparam int TURNS_W    = 16;
   localparam int TALLY_W    = 16;
   localparam int POS_W      = 32;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 72;
   localparam int CSR_INDEX_W = 2;

   // Spike check product and position scaling
   localparam int PROD_W        = SPIKE_W + ELAPSED_W;
   localparam int MDEG_PER_TURN = 360000;
   localparam int MDEG_W        = 19;
   localparam int TP_W          = TURNS_W + MDEG_W + 1;
   localparam int CP_W          = ANGLE_BITS + MDEG_W;

   localparam logic [RAW_W:0] RAW_LIMIT = (RAW_W + 1)'(1) << ANGLE_BITS;
   localparam logic [ANGLE_BITS:0] FULL_TURN = (ANGLE_BITS + 1)'(1) << ANGLE_BITS;
   localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
   localparam logic signed [TURNS_W-1:0] TURNS_MAX = TURNS_W'(16'sh7FFF);
   localparam logic signed [TURNS_W-1:0] TURNS_MIN = TURNS_W'(16'sh8000);

   // Register reset values
   localparam logic [SPIKE_W-1:0]  SPIKE_RATE_RST = SPIKE_W'(206158);
   localparam logic [LIMIT_W-1:0]  LIMIT_RST      = LIMIT_W'(2);
   localparam logic [STATUS_W-1:0] MASK_RST       = STATUS_W'(7);
   localparam logic [ENABLE_W-1:0] ENABLE_RST     = ENABLE_W'(3);

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SPIKE_RATE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ATTEMPT_LIM = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STATUS_MASK = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENC_ENABLE  = 2'd3;

   // Opcodes
   localparam logic OP_READ = 1'b0;
   localparam logic OP_ZERO = 1'b1;

   typedef enum logic [1:0] {
      FAULT_NONE   = 2'd0,
      FAULT_RANGE  = 2'd1,
      FAULT_SPIKE  = 2'd2,
      FAULT_STATUS = 2'd3
   } fault_type;

   // One input word, unpacked
   typedef struct packed {
      logic                 op;
      logic [IDX_W-1:0]     idx;
      logic [RAW_W-1:0]     raw;
      logic                 crc;
      logic [STATUS_W-1:0]  status;
      logic [ELAPSED_W-1:0] elapsed;
   } item_type;

   // Per-encoder entry of the state memory
   typedef struct packed {
      logic [ANGLE_BITS-1:0]       zero_offset;
      logic [ANGLE_BITS-1:0]       prev_corr;
      logic [ANGLE_BITS-1:0]       prev_raw;
      logic signed [TURNS_W-1:0]   turns;
      logic [ATTEMPT_W-1:0]        attempt;
      logic [TALLY_W-1:0]          fail;
   } state_type;

   // Outcome of one word, before position scaling
   typedef struct packed {
      logic [IDX_W-1:0]          enc_id;
      logic signed [TURNS_W-1:0] turns;
      logic [ANGLE_BITS-1:0]     corr;
      logic                      accepted;
      logic                      retry;
      fault_type                 kind;
      logic [TALLY_W-1:0]        tally;
   } result_type;

endpackage

`default_nettype wire

// File: design/vmat_update.sv
// Validation and state update of one encoder entry for one word.
`default_nettype none

module vmat_update (
   input  vmat_pkg::item_type                   item,
   input  vmat_pkg::state_type                  st,
   input  logic [vmat_pkg::PROD_W-1:0]          spike_prod,
   input  logic [vmat_pkg::LIMIT_W-1:0]         attempt_limit,
   input  logic [vmat_pkg::STATUS_W-1:0]        status_mask,
   input  logic [vmat_pkg::ENABLE_W-1:0]        encoder_enable,
   output vmat_pkg::state_type                  st_next,
   output logic                                 live,
   output vmat_pkg::result_type                 res
);
   import vmat_pkg::*;

   logic                          in_range;
   logic [IDX_SPAN-1:0]           en_ext;
   logic                          bad;
   logic [ANGLE_BITS-1:0]         raw;
   logic [ANGLE_BITS-1:0]         corr;
   logic signed [ANGLE_BITS:0]    dlt;
   logic signed [TURNS_W-1:0]     trk_turns;
   logic [ANGLE_BITS-1:0]         diff;
   logic [ANGLE_BITS-1:0]         short_gap;
   logic [PROD_W-1:0]             gap_scaled;
   logic                          spike_hit;
   logic [ATTEMPT_W:0]            cnt;
   logic [TALLY_W-1:0]            fail_inc;
   fault_type                     kind;

   // Angle handling shared by the branches below
   always_comb begin
      in_range = (IDX_W + 1)'(item.idx) < (IDX_W + 1)'(NUM_ENCODERS);
      en_ext   = IDX_SPAN'(encoder_enable);
      live     = in_range && en_ext[item.idx];
      bad      = item.crc || ((RAW_W + 1)'(item.raw) >= RAW_LIMIT);
      raw      = bad ? '0 : item.raw[ANGLE_BITS-1:0];

      // turn counting against the previous corrected angle
      corr = raw - st.zero_offset;
      dlt  = $signed({1'b0, corr}) - $signed({1'b0, st.prev_corr});
      trk_turns = st.turns;
      if (dlt > $signed({1'b0, HALF_TURN})) begin
         if (st.turns != TURNS_MIN) trk_turns = st.turns - TURNS_W'(1);
      end else if (dlt < -$signed({1'b0, HALF_TURN})) begin
         if (st.turns != TURNS_MAX) trk_turns = st.turns + TURNS_W'(1);
      end

      // spike distance, the short way round
      diff = (raw > st.prev_raw) ? raw - st.prev_raw : st.prev_raw - raw;
      short_gap = (diff > HALF_TURN) ? ANGLE_BITS'(FULL_TURN - (ANGLE_BITS + 1)'(diff)) : diff;
      gap_scaled = PROD_W'(short_gap) << SPIKE_FRAC;
      spike_hit  = gap_scaled > spike_prod;

      cnt      = (ATTEMPT_W + 1)'(st.attempt) + (ATTEMPT_W + 1)'(1);
      fail_inc = (st.fail == '1) ? st.fail : st.fail + TALLY_W'(1);
   end

   // Decision and next entry
   always_comb begin
      st_next = st;
      kind    = FAULT_NONE;
      res     = '0;
      res.enc_id = item.idx;
      if (in_range && !live) begin
         res.tally = st.fail;
      end else if (live) begin
         if (bad) kind = FAULT_RANGE;
         if (item.op == OP_ZERO) begin
            if (!bad) begin
               st_next.zero_offset = raw;
               st_next.prev_raw    = raw;
               st_next.prev_corr   = '0;
               st_next.turns       = '0;
               st_next.fail        = '0;
               st_next.attempt     = '0;
               res.accepted        = 1'b1;
            end
         end else begin
            if (!bad && st.prev_raw != '0 && item.elapsed != '0 && spike_hit)
               kind = FAULT_SPIKE;
            if (kind == FAULT_NONE && (item.status & status_mask) != '0)
               kind = FAULT_STATUS;

            if (kind == FAULT_NONE) begin
               st_next.attempt   = '0;
               st_next.fail      = '0;
               st_next.turns     = trk_turns;
               st_next.prev_corr = corr;
               st_next.prev_raw  = raw;
               res.accepted      = 1'b1;
            end else if (cnt < (ATTEMPT_W + 1)'(attempt_limit)) begin
               st_next.attempt = cnt[ATTEMPT_W-1:0];
               res.retry       = 1'b1;
            end else begin
               // final failure: a range fault holds the position
               st_next.attempt = '0;
               st_next.fail    = fail_inc;
               if (kind != FAULT_RANGE) begin
                  st_next.turns     = trk_turns;
                  st_next.prev_corr = corr;
                  st_next.prev_raw  = raw;
                  res.accepted      = 1'b1;
               end
            end
         end
         res.turns = st_next.turns;
         res.corr  = st_next.prev_corr;
         res.kind  = kind;
         res.tally = st_next.fail;
      end
   end

endmodule

`default_nettype wire

// File: design/validated_multiturn_angle_tracker.sv
// Top level: stream pipeline around the per-encoder state memory.
//
// Usage: each req word is either a read attempt (req_tuser = 0) or a zero
// capture (req_tuser = 1) for one encoder; exactly one rsp word comes back
// per req word, in order. Write registers over the csr channel (csr_ready
// is always high) only while the block is idle; it does not enforce this.
// Path: from the req edge to rsp_tvalid a word passes through five
// registers: input register, state memory read, validation and write-back,
// position multipliers, sum and saturation into the output register.
// Throughput: one word per cycle unless stalled. The state memory has one
// read and one write port; a word that follows a word for the same encoder
// gets the written entry from a forwarding register; no interlock is needed.
// Reset: all stage valids clear, registers take their reset values and the
// valid bit of every memory entry clears, so every entry reads as zero
// until written; no clearing pass is needed.
// Stall: every stage holds while the one after it is full and stalled, so
// req_tready falls only once all five stages hold words.
`default_nettype none

module validated_multiturn_angle_tracker (
   input  logic                                  clock,
   input  logic                                  reset,
   // encoder_index, angle_counts, crc_fault, sensor_status, elapsed_us
   input  logic [vmat_pkg::REQ_DATA_W-1:0]       req_tdata,
   // opcode
   input  logic                                  req_tuser,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // encoder_id, position_millideg, turn_count, accepted, retry_request,
   // fault_kind, error_tally, zero pad
   output logic [vmat_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [vmat_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [vmat_pkg::SPIKE_W-1:0]          csr_data
);
   import vmat_pkg::*;

   // Configuration registers
   logic [SPIKE_W-1:0]   spike_rate_ff;
   logic [LIMIT_W-1:0]   attempt_limit_ff;
   logic [STATUS_W-1:0]  status_mask_ff;
   logic [ENABLE_W-1:0]  enable_ff;

   // Pipeline control
   logic rsp_load, s4_load, s3_load, s2_load, s1_load;
   logic s4_move, s3_move, s2_move, s1_move, req_fire;
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, rsp_v_ff;

   // Stage payloads
   item_type            req_item;
   item_type            s1_item_ff;
   item_type            s2_item_ff;
   logic [PROD_W-1:0]   s2_prod_ff;
   logic [PROD_W-1:0]   s2_prod_in;
   result_type          s3_res_ff;
   result_type          s4_res_ff;
   logic signed [TP_W-1:0] s4_tp_ff;
   logic signed [TP_W-1:0] s4_tp_in;
   logic [CP_W-1:0]     s4_cp_ff;
   logic [CP_W-1:0]     s4_cp_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   // State memory and forwarding
   state_type                 mem [NUM_ENCODERS];
   logic [NUM_ENCODERS-1:0]   entry_ok_ff;
   state_type                 rd_ff;
   logic                      rd_ok_ff;
   logic                      byp_ff;
   state_type                 byp_data_ff;
   logic                      byp_in;
   logic [ENC_ADDR_W-1:0]     s1_addr;
   logic [ENC_ADDR_W-1:0]     s2_addr;
   state_type                 s2_state;
   state_type                 s2_next;
   logic                      s2_live;
   logic                      wr_en;
   result_type                s2_res;

   // Position scaling
   logic signed [TP_W-1:0]    turns_ext;
   logic [CP_W-1:0]           cp_adj;
   logic [MDEG_W-1:0]         frac;
   logic signed [TP_W-1:0]    pos_sum;
   logic [POS_W-1:0]          pos_sat;

   localparam logic signed [TP_W-1:0] MDEG_S  = TP_W'(MDEG_PER_TURN);
   localparam logic [CP_W-1:0]        MDEG_U  = CP_W'(MDEG_PER_TURN);
   localparam logic [CP_W-1:0]        CEIL_ADD = CP_W'((FULL_TURN) - 1'b1);
   localparam logic signed [TP_W-1:0] POS_MAX = TP_W'(32'sh7FFFFFFF);
   localparam logic signed [TP_W-1:0] POS_MIN = TP_W'(32'sh80000000);

   // Configuration write port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         spike_rate_ff    <= SPIKE_RATE_RST;
         attempt_limit_ff <= LIMIT_RST;
         status_mask_ff   <= MASK_RST;
         enable_ff        <= ENABLE_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SPIKE_RATE:  spike_rate_ff    <= csr_data;
            CSR_ATTEMPT_LIM: attempt_limit_ff <= csr_data[LIMIT_W-1:0];
            CSR_STATUS_MASK: status_mask_ff   <= csr_data[STATUS_W-1:0];
            CSR_ENC_ENABLE:  enable_ff        <= csr_data[ENABLE_W-1:0];
            default:         spike_rate_ff    <= spike_rate_ff;
         endcase
      end
   end

   // Stage handshakes: a stage loads when empty or when it moves on
   always_comb begin
      rsp_load = !rsp_v_ff || rsp_tready;
      s4_load  = !s4_v_ff || rsp_load;
      s4_move  = s4_v_ff && rsp_load;
      s3_load  = !s3_v_ff || s4_load;
      s3_move  = s3_v_ff && s4_load;
      s2_load  = !s2_v_ff || s3_load;
      s2_move  = s2_v_ff && s3_load;
      s1_load  = !s1_v_ff || s2_load;
      s1_move  = s1_v_ff && s2_load;
      req_fire = req_tvalid && s1_load;
   end

   assign req_tready = s1_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (s1_load)  s1_v_ff  <= req_fire;
         if (s2_load)  s2_v_ff  <= s1_move;
         if (s3_load)  s3_v_ff  <= s2_move;
         if (s4_load)  s4_v_ff  <= s3_move;
         if (rsp_load) rsp_v_ff <= s4_move;
      end
   end

   // Input word unpacking
   always_comb begin
      req_item.op      = req_tuser;
      req_item.idx     = req_tdata[2:0];
      req_item.raw     = req_tdata[23:3];
      req_item.crc     = req_tdata[24];
      req_item.status  = req_tdata[27:25];
      req_item.elapsed = req_tdata[47:28];
   end

   // Memory addresses: an index beyond the encoders reads entry zero, unused
   always_comb begin
      s1_addr = ((IDX_W + 1)'(s1_item_ff.idx) < (IDX_W + 1)'(NUM_ENCODERS)) ?
                s1_item_ff.idx[ENC_ADDR_W-1:0] : '0;
      s2_addr = ((IDX_W + 1)'(s2_item_ff.idx) < (IDX_W + 1)'(NUM_ENCODERS)) ?
                s2_item_ff.idx[ENC_ADDR_W-1:0] : '0;
      s2_prod_in = PROD_W'(spike_rate_ff) * PROD_W'(s1_item_ff.elapsed);
      wr_en  = s2_move && s2_live;
      byp_in = wr_en && s1_v_ff && (s1_addr == s2_addr);
   end

   // Stage 1: input register
   always_ff @(posedge clock) begin
      if (s1_load) s1_item_ff <= req_item;
   end

   // Stage 2 load: memory read, spike product, forwarding from write-back
   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_item_ff  <= s1_item_ff;
         s2_prod_ff  <= s2_prod_in;
         rd_ff       <= mem[s1_addr];
         rd_ok_ff    <= entry_ok_ff[s1_addr];
         byp_data_ff <= s2_next;
      end
      if (wr_en) mem[s2_addr] <= s2_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ok_ff <= '0;
         byp_ff      <= 1'b0;
      end else begin
         if (wr_en)   entry_ok_ff[s2_addr] <= 1'b1;
         if (s2_load) byp_ff <= byp_in;
      end
   end

   // Entry seen by stage 2: forwarded, stored, or the reset value
   always_comb begin
      if (byp_ff)        s2_state = byp_data_ff;
      else if (rd_ok_ff) s2_state = rd_ff;
      else               s2_state = '0;
   end

   vmat_update u_update (
      .item           (s2_item_ff),
      .st             (s2_state),
      .spike_prod     (s2_prod_ff),
      .attempt_limit  (attempt_limit_ff),
      .status_mask    (status_mask_ff),
      .encoder_enable (enable_ff),
      .st_next        (s2_next),
      .live           (s2_live),
      .res            (s2_res)
   );

   // Stage 3: result after write-back
   always_ff @(posedge clock) begin
      if (s3_load) s3_res_ff <= s2_res;
   end

   // Stage 4: millidegree products of whole turns and of the angle
   always_comb begin
      turns_ext = TP_W'($signed(s3_res_ff.turns));
      s4_tp_in  = turns_ext * MDEG_S;
      s4_cp_in  = CP_W'(s3_res_ff.corr) * MDEG_U;
   end

   always_ff @(posedge clock) begin
      if (s4_load) begin
         s4_res_ff <= s3_res_ff;
         s4_tp_ff  <= s4_tp_in;
         s4_cp_ff  <= s4_cp_in;
      end
   end

   // Output: truncate toward zero, add, saturate, pack
   always_comb begin
      cp_adj  = s4_res_ff.turns[TURNS_W-1] ? s4_cp_ff + CEIL_ADD : s4_cp_ff;
      frac    = cp_adj[CP_W-1:ANGLE_BITS];
      pos_sum = s4_tp_ff + $signed(TP_W'(frac));
      if (pos_sum > POS_MAX)      pos_sat = POS_MAX[POS_W-1:0];
      else if (pos_sum < POS_MIN) pos_sat = POS_MIN[POS_W-1:0];
      else                        pos_sat = pos_sum[POS_W-1:0];
      rsp_data_in = {1'b0, s4_res_ff.tally, s4_res_ff.kind, s4_res_ff.retry,
                     s4_res_ff.accepted, s4_res_ff.turns, pos_sat, s4_res_ff.enc_id};
   end

   always_ff @(posedge clock) begin
      if (rsp_load) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tvalid = rsp_v_ff;

   // Checks
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && s2_v_ff && s3_v_ff && s4_v_ff && rsp_v_ff && !rsp_tready) |-> !req_tready)
      else $error("input taken while pipeline is full and stalled");

   a_fwd_taken: assert property (@(posedge clock) disable iff (reset)
      (wr_en && s1_move && (s1_addr == s2_addr)) |=> (byp_ff && s2_v_ff))
      else $error("same-entry word missed the forwarded entry");

   a_no_stray_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ((IDX_W + 1)'(s2_item_ff.idx) < (IDX_W + 1)'(NUM_ENCODERS)))
      else $error("state written for an index beyond the encoders");

   a_retry_kind: assert property (@(posedge clock) disable iff (reset)
      (s2_move && s2_res.retry) |-> (!s2_res.accepted && s2_res.kind != FAULT_NONE))
      else $error("retry without a fault or with an update");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result word changed while stalled");

endmodule

`default_nettype wire
